/* src/lzw_stream_compressor_assert.svh */
// Assertion macros for the LZW stream compressor checker.
// Include by bare file name; no other dependencies.
`ifndef LZW_STREAM_COMPRESSOR_ASSERT_SVH
`define LZW_STREAM_COMPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsc assertion failed");

// Next-cycle implication, disabled during reset.
`define LSC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsc assertion failed");

`endif

/* src/lsc_pkg.sv */
// Shared constants, types and functions of the LZW stream compressor.
// No dependencies; imported by ctrl, datapath, top level and bench.
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

   localparam int DICT_BITS = 12;
   localparam int DICT_SIZE = 1 << DICT_BITS;
   localparam int DCNT_W    = DICT_BITS + 1;
   localparam int ACNT_W    = 9;

   typedef logic [1:0]           mode_type;
   typedef logic [DICT_BITS-1:0] dcode_type;
   typedef logic [DCNT_W-1:0]    dcount_type;

   localparam mode_type MODE_ALPHA    = 2'd0;
   localparam mode_type MODE_COMPRESS = 2'd1;
   localparam mode_type MODE_CLEAR    = 2'd2;

   typedef struct packed {
      logic capture;
      logic alpha_add;
      logic clear_all;
      logic prefix_alpha;
      logic push_unknown;
      logic probe_start;
      logic probe_next;
      logic take_match;
      logic insert_miss;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     last;
      logic     sym_known;
      logic     held;
      logic     slot_valid;
      logic     slot_match;
      logic     clear_done;
      logic     dirty;
      logic     fifo_room;
   } status_type;

   function automatic dcode_type hash_of(input dcode_type prefix, input logic [7:0] sym);
      logic [31:0] p;
      logic [31:0] h;
      p = 32'(prefix);
      h = (p * 32'd40503) ^ (32'(sym) * 32'd157) ^ (p >> 5);
      return h[DICT_BITS-1:0];
   endfunction

   function automatic logic [3:0] bit_length(input dcount_type v);
      logic [7:0] n;
      n = 8'd0;
      for (int i = 0; i < DCNT_W; i++) begin
         if (v[i]) begin
            n = 8'(i + 1);
         end
      end
      return n[3:0];
   endfunction

   function automatic logic [11:0] code12(input dcode_type v);
      logic [31:0] t;
      t = 32'(v);
      return t[11:0];
   endfunction

endpackage

`default_nettype wire

/* src/lsc_if.sv */
// Valid/ready channel interfaces for request and response items.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] symbol;
   logic       last;
   modport source (output valid, mode, symbol, last, input ready);
   modport sink (input valid, mode, symbol, last, output ready);
endinterface

interface lsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] code;
   logic        end_of_text;
   logic [3:0]  code_width;
   logic        unknown_symbol;
   modport source (output valid, code, end_of_text, code_width, unknown_symbol, input ready);
   modport sink (input valid, code, end_of_text, code_width, unknown_symbol, output ready);
endinterface

`default_nettype wire

/* src/lsc_ctrl.sv */
// Controller of the LZW stream compressor: sequences decode, probe and clear.
// Depends on lsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lsc_pkg::status_type status,
   output lsc_pkg::cmd_type    cmd
);
   import lsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_PROBE, S_CHECK, S_FINISH, S_CLEAR
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE) && status.fifo_room;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.mode)
               MODE_ALPHA: begin
                  cmd.alpha_add = 1'b1;
                  state_in      = S_IDLE;
               end
               MODE_COMPRESS: begin
                  if (!status.sym_known) begin
                     cmd.push_unknown = 1'b1;
                     state_in = status.last ? S_FINISH : S_IDLE;
                  end else if (!status.held) begin
                     cmd.prefix_alpha = 1'b1;
                     state_in = status.last ? S_FINISH : S_IDLE;
                  end else begin
                     cmd.probe_start = 1'b1;
                     state_in        = S_PROBE;
                  end
               end
               MODE_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  state_in      = S_CLEAR;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PROBE: state_in = S_CHECK;
         S_CHECK: begin
            if (!status.slot_valid) begin
               cmd.insert_miss = 1'b1;
               state_in = status.last ? S_FINISH : S_IDLE;
            end else if (status.slot_match) begin
               cmd.take_match = 1'b1;
               state_in = status.last ? S_FINISH : S_IDLE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = status.dirty ? S_CLEAR : S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* src/lsc_datapath.sv */
// Datapath of the LZW stream compressor: alphabet, hashed phrase table,
// match registers and response queue. Depends on lsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  lsc_pkg::cmd_type    cmd,
   output lsc_pkg::status_type status,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_symbol,
   input  logic                req_last,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [11:0]         rsp_code,
   output logic                rsp_end_of_text,
   output logic [3:0]          rsp_code_width,
   output logic                rsp_unknown_symbol
);
   import lsc_pkg::*;

   typedef struct packed {
      logic      valid;
      dcode_type prefix;
      logic [7:0] sym;
      dcode_type code;
   } slot_type;

   typedef struct packed {
      logic [11:0] code;
      logic        eot;
      logic [3:0]  width;
      logic        unk;
   } out_type;

   mode_type    mode_ff;
   logic [7:0]  sym_ff;
   logic        last_ff;
   logic [7:0]  alpha_rd_ff;
   dcode_type   hash_ff;
   slot_type    slot_rd_ff;

   logic [255:0]      alpha_valid_ff, alpha_valid_in;
   logic [ACNT_W-1:0] alpha_count_ff, alpha_count_in;
   dcount_type        next_free_ff, next_free_in;
   dcode_type         prefix_ff, prefix_in;
   logic              held_ff, held_in;
   dcode_type         slot_ff, slot_in;
   logic              dirty_ff, dirty_in;
   dcode_type         clr_cnt_ff, clr_cnt_in;

   logic [7:0] alpha_mem [256];
   slot_type   phrase_mem [DICT_SIZE];

   out_type    fifo_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   logic      alpha_we, slot_we, push, pop, sym_known;
   dcode_type slot_waddr, alpha_code;
   slot_type  slot_wdata;
   out_type   push_data, head;

   assign sym_known  = alpha_valid_ff[sym_ff];
   assign alpha_code = DICT_BITS'(alpha_rd_ff);

   always_comb begin
      alpha_valid_in = alpha_valid_ff;
      alpha_count_in = alpha_count_ff;
      next_free_in   = next_free_ff;
      prefix_in      = prefix_ff;
      held_in        = held_ff;
      slot_in        = slot_ff;
      dirty_in       = dirty_ff;
      clr_cnt_in     = clr_cnt_ff;
      alpha_we       = 1'b0;
      slot_we        = 1'b0;
      slot_waddr     = clr_cnt_ff;
      slot_wdata     = '0;
      push           = 1'b0;
      push_data      = '0;
      if (cmd.alpha_add && !held_ff && !sym_known) begin
         alpha_we               = 1'b1;
         alpha_valid_in[sym_ff] = 1'b1;
         alpha_count_in         = alpha_count_ff + 1'b1;
         next_free_in           = DCNT_W'(alpha_count_ff + 1'b1);
      end
      if (cmd.clear_all) begin
         alpha_valid_in = '0;
         alpha_count_in = '0;
         next_free_in   = '0;
         held_in        = 1'b0;
         prefix_in      = '0;
         dirty_in       = 1'b1;
      end
      if (cmd.prefix_alpha) begin
         prefix_in = alpha_code;
         held_in   = 1'b1;
      end
      if (cmd.push_unknown) begin
         push          = 1'b1;
         push_data.unk = 1'b1;
      end
      if (cmd.probe_start) begin
         slot_in = hash_ff;
      end
      if (cmd.probe_next) begin
         slot_in = slot_ff + 1'b1;
      end
      if (cmd.take_match) begin
         prefix_in = slot_rd_ff.code;
      end
      if (cmd.insert_miss) begin
         push           = 1'b1;
         push_data.code = code12(prefix_ff);
         if (!next_free_ff[DICT_BITS]) begin
            slot_we    = 1'b1;
            slot_waddr = slot_ff;
            slot_wdata = '{valid: 1'b1, prefix: prefix_ff, sym: sym_ff,
                           code: next_free_ff[DICT_BITS-1:0]};
            next_free_in = next_free_ff + 1'b1;
            dirty_in     = 1'b1;
         end
         prefix_in = alpha_code;
      end
      if (cmd.finish) begin
         if (held_ff) begin
            push            = 1'b1;
            push_data.code  = code12(prefix_ff);
            push_data.eot   = 1'b1;
            push_data.width = (next_free_ff != '0) ? bit_length(next_free_ff - 1'b1) : 4'd0;
         end
         next_free_in = DCNT_W'(alpha_count_ff);
         held_in      = 1'b0;
         prefix_in    = '0;
      end
      if (cmd.clear_step) begin
         slot_we    = 1'b1;
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (status.clear_done) begin
            dirty_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_valid_ff <= '0;
         alpha_count_ff <= '0;
         next_free_ff   <= '0;
         prefix_ff      <= '0;
         held_ff        <= 1'b0;
         slot_ff        <= '0;
         dirty_ff       <= 1'b1;
         clr_cnt_ff     <= '0;
      end else begin
         alpha_valid_ff <= alpha_valid_in;
         alpha_count_ff <= alpha_count_in;
         next_free_ff   <= next_free_in;
         prefix_ff      <= prefix_in;
         held_ff        <= held_in;
         slot_ff        <= slot_in;
         dirty_ff       <= dirty_in;
         clr_cnt_ff     <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         sym_ff      <= req_symbol;
         last_ff     <= req_last;
         alpha_rd_ff <= alpha_mem[req_symbol];
         hash_ff     <= hash_of(prefix_ff, req_symbol);
      end
   end

   always_ff @(posedge clock) begin
      if (alpha_we) begin
         alpha_mem[sym_ff] <= alpha_count_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         phrase_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= phrase_mem[slot_ff];
   end

   assign pop = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head               = fifo_ff[rd_ptr_ff];
   assign rsp_valid          = (count_ff != 3'd0);
   assign rsp_code           = head.code;
   assign rsp_end_of_text    = head.eot;
   assign rsp_code_width     = head.width;
   assign rsp_unknown_symbol = head.unk;

   assign status.mode       = mode_ff;
   assign status.last       = last_ff;
   assign status.sym_known  = sym_known;
   assign status.held       = held_ff;
   assign status.slot_valid = slot_rd_ff.valid;
   assign status.slot_match = (slot_rd_ff.prefix == prefix_ff) && (slot_rd_ff.sym == sym_ff);
   assign status.clear_done = (clr_cnt_ff == dcode_type'(DICT_SIZE - 1));
   assign status.dirty      = dirty_ff;
   assign status.fifo_room  = (count_ff < 3'd3);

endmodule

`default_nettype wire

/* src/lzw_stream_compressor.sv */
// Steps: a byte is accepted in idle and decoded; the first known byte of a text becomes the
// match, later ones probe and check slots until a free or matching slot decides, and a miss
// emits the match code; an unknown byte is flagged at decode; a last byte adds a finish step.
// Reset: clearing pass of the phrase table, ready low. Bytes enter only in idle with queue room.
// The same pass follows mode 2 and each end of text that added entries.
// Top level of the LZW stream compressor; depends on lsc_pkg, lsc_if, lsc_ctrl, lsc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module lzw_stream_compressor (
   input logic       clock,
   input logic       reset,
   lsc_req_if.sink   req_chan,
   lsc_rsp_if.source rsp_chan
);
   import lsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lsc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_mode           (req_chan.mode),
      .req_symbol         (req_chan.symbol),
      .req_last           (req_chan.last),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_code           (rsp_chan.code),
      .rsp_end_of_text    (rsp_chan.end_of_text),
      .rsp_code_width     (rsp_chan.code_width),
      .rsp_unknown_symbol (rsp_chan.unknown_symbol)
   );

endmodule

`default_nettype wire

/* src/lsc_checker.sv */
// Port-level checker for the LZW stream compressor, bound to the top level.
// Depends on lzw_stream_compressor_assert.svh and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_stream_compressor_assert.svh"

module lsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_code,
   input logic        rsp_end_of_text,
   input logic [3:0]  rsp_code_width,
   input logic        rsp_unknown_symbol
);

   `LSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `LSC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_code) && $stable(rsp_end_of_text) && $stable(rsp_unknown_symbol))
   `LSC_ASSERT_NOW(a_width_at_end, clock, reset, rsp_valid && !rsp_end_of_text, rsp_code_width == 4'd0)
   `LSC_ASSERT_NOW(a_unknown_clean, clock, reset, rsp_valid && rsp_unknown_symbol, rsp_code == 12'd0 && !rsp_end_of_text)
   `LSC_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

endmodule

bind lzw_stream_compressor lsc_checker u_lsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_code           (rsp_chan.code),
   .rsp_end_of_text    (rsp_chan.end_of_text),
   .rsp_code_width     (rsp_chan.code_width),
   .rsp_unknown_symbol (rsp_chan.unknown_symbol)
);

`default_nettype wire

/* verif/tb_lzw_stream_compressor.sv */
// Self-checking bench for lzw_stream_compressor: drives byte items, predicts codes.
// Needs lsc_pkg, lsc_if and lzw_stream_compressor; the code predictor is a small class.
`timescale 1ns / 1ps

module tb_lzw_stream_compressor;
   import lsc_pkg::*;

   localparam int TABLE_SIZE = 1 << DICT_BITS;
   localparam int TABLE_MASK = TABLE_SIZE - 1;
   localparam int STALL_LIMIT = 30000;
   localparam mode_type MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [11:0] code;
      logic        end_of_text;
      logic [3:0]  code_width;
      logic        unknown_symbol;
   } code_item_t;

   class lzw_scoreboard;
      bit         sym_known[256];
      int         sym_code[256];
      int         alpha_size;
      bit         slot_used[TABLE_SIZE];
      int         slot_prefix[TABLE_SIZE];
      int         slot_byte[TABLE_SIZE];
      int         slot_code[TABLE_SIZE];
      int         free_code;
      int         match_code;
      bit         in_match;
      code_item_t pending_codes[$];
      int         errors;

      function void clear_phrases();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         free_code = alpha_size;
         in_match = 1'b0;
         match_code = 0;
      endfunction

      function void clear_all();
         foreach (sym_known[i]) sym_known[i] = 1'b0;
         alpha_size = 0;
         clear_phrases();
      endfunction

      function int slot_hash(int p, int b);
         bit [31:0] h;
         h = (32'(p) * 32'd40503) ^ (32'(b) * 32'd157) ^ (32'(p) >> 5);
         return int'(h) & TABLE_MASK;
      endfunction

      function int width_of(int v);
         int n;
         n = 0;
         while (v != 0) begin
            v = v >> 1;
            n++;
         end
         return n;
      endfunction

      function void push_code(int c, bit eot, int w, bit unk);
         code_item_t r;
         r.code = 12'(c);
         r.end_of_text = eot;
         r.code_width = 4'(w);
         r.unknown_symbol = unk;
         pending_codes.push_back(r);
      endfunction

      function void close_text();
         if (in_match)
            push_code(match_code, 1'b1, (free_code != 0) ? width_of(free_code - 1) : 0, 1'b0);
         clear_phrases();
      endfunction

      function void note_byte(mode_type m, int s, bit l);
         int  h;
         int  slot;
         bit  hit;
         if (m == MODE_CLEAR) begin
            clear_all();
            return;
         end
         if (m == MODE_ALPHA) begin
            if (!in_match && !sym_known[s]) begin
               sym_known[s] = 1'b1;
               sym_code[s] = alpha_size;
               alpha_size++;
               free_code = alpha_size;
            end
            return;
         end
         if (m != MODE_COMPRESS) return;
         if (!sym_known[s]) begin
            push_code(0, 1'b0, 0, 1'b1);
            if (l) close_text();
            return;
         end
         if (!in_match) begin
            match_code = sym_code[s];
            in_match = 1'b1;
         end else begin
            h = slot_hash(match_code, s);
            slot = TABLE_SIZE;
            hit = 1'b0;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               int k;
               k = (h + i) & TABLE_MASK;
               if (!slot_used[k]) begin
                  slot = k;
                  break;
               end
               if (slot_prefix[k] == match_code && slot_byte[k] == s) begin
                  slot = k;
                  hit = 1'b1;
                  break;
               end
            end
            if (hit) begin
               match_code = slot_code[slot];
            end else begin
               push_code(match_code, 1'b0, 0, 1'b0);
               if (slot < TABLE_SIZE && free_code < TABLE_SIZE) begin
                  slot_used[slot] = 1'b1;
                  slot_prefix[slot] = match_code;
                  slot_byte[slot] = s;
                  slot_code[slot] = free_code;
                  free_code++;
               end
               match_code = sym_code[s];
            end
         end
         if (l) close_text();
      endfunction

      function void check_code(code_item_t got);
         code_item_t want;
         if (pending_codes.size() == 0) begin
            $error("unexpected result: code %0d", got.code);
            errors++;
            return;
         end
         want = pending_codes.pop_front();
         if (got.code !== want.code) begin
            $error("code: expected %0d, actual %0d", want.code, got.code);
            errors++;
         end
         if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %0d, actual %0d", want.end_of_text, got.end_of_text);
            errors++;
         end
         if (got.code_width !== want.code_width) begin
            $error("code_width: expected %0d, actual %0d", want.code_width, got.code_width);
            errors++;
         end
         if (got.unknown_symbol !== want.unknown_symbol) begin
            $error("unknown_symbol: expected %0d, actual %0d",
                   want.unknown_symbol, got.unknown_symbol);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idling;
   int   bytes_sent;
   int   stall_count;
   int   alpha_list[$];
   lzw_scoreboard codes_sb;

   lsc_req_if req_chan();
   lsc_rsp_if rsp_chan();

   lzw_stream_compressor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= idling ? ($urandom_range(99) >= 30) : 1'b1;
   end

   always @(posedge clock) begin
      code_item_t got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.code = rsp_chan.code;
         got.end_of_text = rsp_chan.end_of_text;
         got.code_width = rsp_chan.code_width;
         got.unknown_symbol = rsp_chan.unknown_symbol;
         codes_sb.check_code(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("tb_lzw_stream_compressor: FAIL");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic send_byte(mode_type m, int s, bit l);
      while (idling && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= m;
      req_chan.symbol <= 8'(s);
      req_chan.last <= l;
      do @(posedge clock); while (!req_chan.ready);
      codes_sb.note_byte(m, s, l);
      if (m != MODE_UNUSED) bytes_sent++;
   endtask

   task automatic drain_codes();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (codes_sb.pending_codes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic load_alphabet(int n);
      alpha_list.delete();
      send_byte(MODE_CLEAR, $urandom_range(255), 1'($urandom_range(1)));
      if (n >= 256) begin
         for (int i = 0; i < 256; i++) begin
            send_byte(MODE_ALPHA, i, 1'($urandom_range(1)));
            alpha_list.push_back(i);
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            int b;
            b = $urandom_range(255);
            send_byte(MODE_ALPHA, b, 1'($urandom_range(1)));
            alpha_list.push_back(b);
         end
      end
   endtask

   task automatic send_text(int len, int noise_pct);
      for (int i = 0; i < len; i++) begin
         int b;
         if ($urandom_range(99) < noise_pct) begin
            send_byte($urandom_range(1) ? MODE_UNUSED : MODE_ALPHA,
                      $urandom_range(255), 1'($urandom_range(1)));
         end
         if ($urandom_range(99) < noise_pct)
            b = $urandom_range(255);
         else
            b = alpha_list[$urandom_range(alpha_list.size() - 1)];
         send_byte(MODE_COMPRESS, b, i == len - 1);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      idling = 1'b0;
      bytes_sent = 0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_ALPHA;
      req_chan.symbol = 8'd0;
      req_chan.last = 1'b0;
      codes_sb = new();
      codes_sb.clear_all();
      codes_sb.errors = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(MODE_UNUSED, 8'hFF, 1'b1);
      send_byte(MODE_COMPRESS, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'h7E, 1'b1);
      send_byte(MODE_ALPHA, 8'h00, 1'b0);
      send_byte(MODE_ALPHA, 8'hFF, 1'b1);
      send_byte(MODE_ALPHA, 8'h41, 1'b0);
      send_byte(MODE_ALPHA, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'hFF, 1'b1);
      send_byte(MODE_COMPRESS, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'hAA, 1'b0);
      send_byte(MODE_ALPHA, 8'h55, 1'b0);
      send_byte(MODE_COMPRESS, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'hFF, 1'b0);
      send_byte(MODE_COMPRESS, 8'h13, 1'b1);
      for (int i = 0; i < 5; i++) send_byte(MODE_COMPRESS, 8'h41, i == 4);
      send_byte(MODE_COMPRESS, 8'h41, 1'b0);
      send_byte(MODE_CLEAR, 8'h00, 1'b0);
      send_byte(MODE_COMPRESS, 8'h41, 1'b1);
      drain_codes();

      idling = 1'b1;
      while (bytes_sent < 600) begin
         int r;
         r = $urandom_range(99);
         load_alphabet(r < 10 ? 256 : (r < 20 ? 1 : $urandom_range(2, 12)));
         repeat ($urandom_range(1, 6)) begin
            send_text($urandom_range(1, 40), $urandom_range(1) ? 0 : 8);
            if ($urandom_range(99) < 15) drain_codes();
         end
         idling = ($urandom_range(99) >= 15);
      end

      idling = 1'b0;
      load_alphabet(256);
      send_text(120, 0);
      send_text(30, 0);
      idling = 1'b1;
      send_text(20, 5);

      drain_codes();
      if (codes_sb.errors == 0) begin
         $display("tb_lzw_stream_compressor: PASS");
      end else begin
         $display("tb_lzw_stream_compressor: FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/lsc_pkg.sv
src/lsc_if.sv
src/lsc_ctrl.sv
src/lsc_datapath.sv
src/lzw_stream_compressor.sv
src/lsc_checker.sv
verif/tb_lzw_stream_compressor.sv
